[design/ssa_pkg.sv]
package ssa_pkg;

   localparam int SLOTS  = 1024;
   localparam int POOL   = 65536;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = SLOT_W + 1;
   localparam int BASE_W = $clog2(POOL);
   localparam int LEN_W  = BASE_W + 1;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_SET   = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      STS_OK    = 3'd0,
      STS_SPACE = 3'd1,
      STS_BAD   = 3'd2,
      STS_OVER  = 3'd3,
      STS_NOCFG = 3'd4
   } status_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [LEN_W-1:0]  capacity;
      logic              is_free;
      logic [LEN_W-1:0]  used;
   } slot_entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] granted_slot;
      logic [BASE_W-1:0] block_base;
      logic [LEN_W-1:0]  block_capacity;
      logic [LEN_W-1:0]  block_used;
      status_type        status;
   } result_type;

endpackage

[design/ssa_if.sv]
interface ssa_req_if;
   import ssa_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             action;
   logic signed [SLOT_W:0] slot_index;
   logic [LEN_W-1:0]       request_length;

   modport source (output valid, action, slot_index, request_length, input ready);
   modport sink (input valid, action, slot_index, request_length, output ready);
endinterface

interface ssa_rsp_if;
   import ssa_pkg::*;
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] granted_slot;
   logic [BASE_W-1:0] block_base;
   logic [LEN_W-1:0]  block_capacity;
   logic [LEN_W-1:0]  block_used;
   logic [2:0]        status;

   modport source (output valid, granted_slot, block_base, block_capacity, block_used,
                   status, input ready);
   modport sink (input valid, granted_slot, block_base, block_capacity, block_used,
                 status, output ready);
endinterface

[design/stack_slot_allocator.sv]
// Slot allocator over a pool carved as a stack.
// req_ch carries one transaction per action (allocate, free, set length, query);
// rsp_ch returns exactly one result transaction for each, in order.
// csr_write/csr_wdata set default_length; write it only while the block is idle.
// Slot state lives in one synchronous RAM (one read, one write per cycle).
// Simple results go from acceptance straight to the output stage; set, query and
// a free below the top first read the slot entry in S_SLOT_RD.
// Allocate scans slot by slot from the free hint to the stack top.
// Freeing the top slot walks down the stack over each freed slot beneath it.
// One transaction is in flight at a time; req_ch.ready is high in idle, also
// while a finished result still waits in the output register.
// Reset clears the counters, the hint, the stack top and default_length; the
// RAM needs no clearing pass. A stalled rsp_ch holds its result and the next
// result waits in the block until the output register is taken.
module stack_slot_allocator (
   input  logic               clock,
   input  logic               reset,
   ssa_req_if.sink            req_ch,
   ssa_rsp_if.source          rsp_ch,
   input  logic               csr_write,
   input  logic [ssa_pkg::LEN_W-1:0] csr_wdata
);
   import ssa_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SLOT_RD  = 7'b0000010,
      S_SCAN     = 7'b0000100,
      S_SCAN_CHK = 7'b0001000,
      S_POP      = 7'b0010000,
      S_POP_CHK  = 7'b0100000,
      S_EMIT     = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   action_type       act_ff, act_in;
   logic [SLOT_W:0]  idx_ff, idx_in;
   logic [LEN_W-1:0] req_ff, req_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] hint_ff, hint_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0] stop_ff, stop_in;
   logic [LEN_W-1:0] dflt_ff;
   logic             skip_ff, skip_in;
   result_type       res_ff, res_in;
   result_type       rsp_ff;
   logic             rsp_valid_ff;
   logic             load_rsp;

   slot_entry_type   mem [SLOTS];
   slot_entry_type   rd_ff;
   slot_entry_type   mem_wdata;
   logic             mem_we;
   logic [SLOT_W-1:0] mem_waddr, mem_raddr;

   logic [LEN_W:0]   push_end;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign load_rsp     = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign push_end     = {1'b0, stop_ff} + {1'b0, len_ff};

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      idx_in    = idx_ff;
      req_in    = req_ff;
      len_in    = len_ff;
      top_in    = top_ff;
      hint_in   = hint_ff;
      ptr_in    = ptr_ff;
      stop_in   = stop_ff;
      skip_in   = skip_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[SLOT_W-1:0];
      mem_wdata = rd_ff;
      mem_raddr = idx_ff[SLOT_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               act_in = action_type'(req_ch.action);
               idx_in = req_ch.slot_index;
               req_in = req_ch.request_length;
               len_in = (req_ch.request_length != '0) ? req_ch.request_length : dflt_ff;
               res_in = '{req_ch.slot_index[SLOT_W-1:0], '0, '0, '0, STS_OK};
               mem_raddr = req_ch.slot_index[SLOT_W-1:0];
               if ((req_ch.action == ACT_ALLOC || req_ch.action == ACT_FREE)
                   && dflt_ff == '0) begin
                  res_in   = '{'0, '0, '0, '0, STS_NOCFG};
                  state_in = S_EMIT;
               end else if (req_ch.action == ACT_ALLOC) begin
                  ptr_in   = hint_ff;
                  skip_in  = 1'b1;
                  state_in = S_SCAN;
               end else if (req_ch.action == ACT_FREE && (&req_ch.slot_index)) begin
                  state_in = S_EMIT;
               end else if (req_ch.slot_index[SLOT_W]
                            || {1'b0, req_ch.slot_index[SLOT_W-1:0]} >= top_ff) begin
                  res_in.status = STS_BAD;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_SLOT_RD;
               end
            end
         end
         S_SLOT_RD: begin
            state_in = S_EMIT;
            res_in   = '{idx_ff[SLOT_W-1:0], rd_ff.base, rd_ff.capacity, rd_ff.used, STS_OK};
            if (rd_ff.is_free) begin
               res_in = '{idx_ff[SLOT_W-1:0], '0, '0, '0, STS_BAD};
            end else begin
               case (act_ff)
                  ACT_SET: begin
                     if (req_ff > rd_ff.capacity) begin
                        res_in.status = STS_OVER;
                     end else begin
                        mem_we            = 1'b1;
                        mem_wdata.used    = req_ff;
                        res_in.block_used = req_ff;
                     end
                  end
                  ACT_FREE: begin
                     mem_we            = 1'b1;
                     mem_wdata.is_free = 1'b1;
                     if (idx_ff < hint_ff) begin
                        hint_in = idx_ff;
                     end
                     if (idx_ff + 1'b1 == top_ff) begin
                        top_in   = idx_ff;
                        state_in = S_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            mem_raddr = ptr_ff[SLOT_W-1:0];
            if (ptr_ff >= top_ff) begin
               state_in = S_EMIT;
               if (top_ff == CNT_W'(SLOTS) || push_end > (LEN_W+1)'(POOL)) begin
                  res_in = '{'0, '0, '0, '0, STS_SPACE};
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = top_ff[SLOT_W-1:0];
                  mem_wdata = '{stop_ff[BASE_W-1:0], len_ff, 1'b0, '0};
                  res_in    = '{top_ff[SLOT_W-1:0], stop_ff[BASE_W-1:0], len_ff, '0, STS_OK};
                  stop_in   = push_end[LEN_W-1:0];
                  top_in    = top_ff + 1'b1;
                  if (hint_ff == top_ff) begin
                     hint_in = hint_ff + 1'b1;
                  end
               end
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_SCAN;
            if (rd_ff.is_free) begin
               skip_in = 1'b0;
               if (rd_ff.capacity >= len_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = ptr_ff[SLOT_W-1:0];
                  mem_wdata = '{rd_ff.base, rd_ff.capacity, 1'b0, '0};
                  res_in    = '{ptr_ff[SLOT_W-1:0], rd_ff.base, rd_ff.capacity, '0, STS_OK};
                  if (ptr_ff == hint_ff) begin
                     hint_in = hint_ff + 1'b1;
                  end
                  state_in = S_EMIT;
               end
            end else if (skip_ff) begin
               hint_in = ptr_ff + 1'b1;
            end
         end
         S_POP: begin
            mem_raddr = SLOT_W'(top_ff - 1'b1);
            if (top_ff == '0) begin
               stop_in  = '0;
               state_in = S_EMIT;
            end else begin
               state_in = S_POP_CHK;
            end
         end
         S_POP_CHK: begin
            if (rd_ff.is_free) begin
               top_in   = top_ff - 1'b1;
               state_in = S_POP;
            end else begin
               stop_in  = {1'b0, rd_ff.base} + rd_ff.capacity;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         hint_ff      <= '0;
         stop_ff      <= '0;
         dflt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         hint_ff  <= hint_in;
         stop_ff  <= stop_in;
         if (csr_write) begin
            dflt_ff <= csr_wdata;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      idx_ff  <= idx_in;
      req_ff  <= req_in;
      len_ff  <= len_in;
      ptr_ff  <= ptr_in;
      skip_ff <= skip_in;
      res_ff  <= res_in;
      if (load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.granted_slot   = rsp_ff.granted_slot;
   assign rsp_ch.block_base     = rsp_ff.block_base;
   assign rsp_ch.block_capacity = rsp_ff.block_capacity;
   assign rsp_ch.block_used     = rsp_ff.block_used;
   assign rsp_ch.status         = rsp_ff.status;

endmodule

[design/ssa_checker.sv]
module ssa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ssa_pkg::SLOT_W-1:0]  rsp_slot,
   input logic [ssa_pkg::BASE_W-1:0]  rsp_base,
   input logic [ssa_pkg::LEN_W-1:0]   rsp_cap,
   input logic [ssa_pkg::LEN_W-1:0]   rsp_used,
   input logic [2:0]                  rsp_status
);
   import ssa_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
      else $error("stalled result changed");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STS_NOCFG)
      else $error("status out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_NOCFG || rsp_status == STS_SPACE)
      |-> rsp_slot == '0 && rsp_base == '0 && rsp_cap == '0 && rsp_used == '0)
      else $error("failed allocate carries data");

   a_used_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_OK |-> rsp_used <= rsp_cap)
      else $error("used length over capacity");

endmodule

bind stack_slot_allocator ssa_checker u_ssa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_slot   (rsp_ch.granted_slot),
   .rsp_base   (rsp_ch.block_base),
   .rsp_cap    (rsp_ch.block_capacity),
   .rsp_used   (rsp_ch.block_used),
   .rsp_status (rsp_ch.status)
);
